### hdl/pic_pkg.sv
// Shared definitions for the platform interrupt controller.
// Holds default sizes, register map offsets, action and register codes.
// No dependencies.
package pic_pkg;

  localparam int NUM_SOURCES_DEF   = 31;
  localparam int NUM_CONTEXTS_DEF  = 4;
  localparam int PRIORITY_BITS_DEF = 3;

  // Width of the per-context interrupt output.
  localparam int CTX_IRQ_W = 4;

  localparam logic [1:0] ACT_READ    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_REQUEST = 2'd2;

  localparam logic [21:0] OFS_PENDING = 22'h001000;
  localparam logic [21:0] OFS_ENABLE  = 22'h002000;
  localparam logic [21:0] OFS_CONTEXT = 22'h200000;

  localparam int ENABLE_SHIFT  = 7;   // 0x80 bytes per context enable block
  localparam int CONTEXT_SHIFT = 12;  // 0x1000 bytes per context block

  localparam logic [11:0] REG_THRESHOLD = 12'h000;
  localparam logic [11:0] REG_CLAIM     = 12'h004;

  localparam logic [2:0] RK_NONE   = 3'd0;
  localparam logic [2:0] RK_PRIO   = 3'd1;
  localparam logic [2:0] RK_PEND   = 3'd2;
  localparam logic [2:0] RK_ENABLE = 3'd3;
  localparam logic [2:0] RK_THRESH = 3'd4;
  localparam logic [2:0] RK_CLAIM  = 3'd5;

  // Control from the sequencer to the arbitration unit.
  typedef struct packed {
    logic init;   // load thresholds and clear the best ids
    logic step;   // compare the candidate on the inputs
  } arb_ctl_t;

endpackage

### hdl/pic_prio_ram.sv
// Source priority store of the interrupt controller.
// One write port and one read port with registered read data.
// No package dependencies.
module pic_prio_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/pic_arb.sv
// Arbitration lanes of the interrupt controller: one candidate per cycle of
// ctl.step is compared with every lane's running best. Uses pic_pkg::arb_ctl_t.
module pic_arb #(
  parameter int LANES = 5,
  parameter int IDW   = 5,
  parameter int PW    = 3
) (
  input  logic                       clk,
  input  pic_pkg::arb_ctl_t          ctl,
  input  logic [IDW-1:0]             cand_id,
  input  logic [PW-1:0]              cand_prio,
  input  logic [LANES-1:0]           elig,
  input  logic [LANES-1:0][PW-1:0]   thr,
  output logic [LANES-1:0][IDW-1:0]  best_id
);

  logic [LANES-1:0][PW-1:0]  best_prio_r, best_prio_nxt;
  logic [LANES-1:0][IDW-1:0] best_id_r, best_id_nxt;

  // A strictly greater priority is needed to win, so on a tie the source
  // seen first, the lower id, keeps the lane.
  always_comb begin
    best_prio_nxt = best_prio_r;
    best_id_nxt   = best_id_r;
    for (int l = 0; l < LANES; l++) begin
      if (ctl.init) begin
        best_prio_nxt[l] = thr[l];
        best_id_nxt[l]   = '0;
      end else if (ctl.step && elig[l] && (cand_prio > best_prio_r[l])) begin
        best_prio_nxt[l] = cand_prio;
        best_id_nxt[l]   = cand_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_prio_r <= best_prio_nxt;
    best_id_r   <= best_id_nxt;
  end

  assign best_id = best_id_r;

endmodule

### hdl/platform_interrupt_controller.sv
// A bus access or source request is taken when start is high and busy is
// low. Each item runs an execute state, a scan of the source table and an
// end state before the out_valid strobe; a claim read scans the source
// table once to pick the claimed source and once more for the context
// interrupt lines. The scan walks the single read port of the priority RAM
// one source per cycle. After reset the block is busy while it zeroes the
// priority RAM. Each result is shown for exactly one cycle with out_valid
// high and cannot be held off by the receiver.
//
// Top level of the interrupt controller: sequencer, register file, decode.
// Depends on pic_pkg, pic_prio_ram and pic_arb.
module platform_interrupt_controller #(
  parameter int NUM_SOURCES   = pic_pkg::NUM_SOURCES_DEF,
  parameter int NUM_CONTEXTS  = pic_pkg::NUM_CONTEXTS_DEF,
  parameter int PRIORITY_BITS = pic_pkg::PRIORITY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [21:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic [4:0]  in_source_id,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic        out_bus_error,
  output logic [pic_pkg::CTX_IRQ_W-1:0] out_context_irq
);

  localparam int NUM_WORDS = NUM_SOURCES / 32 + 1;
  localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int VIW       = WW + 5;
  localparam int VW        = 1 << VIW;
  localparam int IDW       = $clog2(NUM_SOURCES + 1);
  localparam int CW        = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int PW        = PRIORITY_BITS;
  localparam int NL        = (NUM_CONTEXTS < pic_pkg::CTX_IRQ_W) ?
                             NUM_CONTEXTS : pic_pkg::CTX_IRQ_W;
  localparam int LANES     = NL + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    act_r, act_nxt;
  logic [21:0]   addr_r, addr_nxt;
  logic [31:0]   data_r, data_nxt;
  logic [4:0]    src_r, src_nxt;
  logic [IDW-1:0] clr_r, clr_nxt;
  logic [VW-1:0] pend_r, pend_nxt;
  logic [VW-1:0] gw_r, gw_nxt;
  logic [VW-1:0] en_r [NUM_CONTEXTS];
  logic [VW-1:0] en_nxt [NUM_CONTEXTS];
  logic [PW-1:0] thr_r [NUM_CONTEXTS];
  logic [PW-1:0] thr_nxt [NUM_CONTEXTS];
  logic [IDW-1:0] scan_id_r, scan_id_nxt;
  logic          iss_r, iss_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IDW-1:0] cmp_id_r, cmp_id_nxt;
  logic          claim_r, claim_nxt;
  logic          prd_r, prd_nxt;
  logic [31:0]   rdata_r, rdata_nxt;
  logic          err_r, err_nxt;
  logic [pic_pkg::CTX_IRQ_W-1:0] irq_r, irq_nxt;
  logic          ov_r, ov_nxt;

  // Decode of the latched address.
  logic [2:0]    kind;
  logic [9:0]    pidx;
  logic [9:0]    wd;
  logic [13:0]   ci;
  logic [21:0]   off_e;
  logic [21:0]   off_c;
  logic [11:0]   creg;
  logic [IDW-1:0] didx;
  logic [WW-1:0] dword;
  logic [CW-1:0] dctx;
  logic [VW-1:0] legal;
  logic [31:0]   wmask;

  logic          ram_we;
  logic [IDW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic [IDW-1:0] ram_raddr;
  logic [PW-1:0] ram_rdata;

  pic_pkg::arb_ctl_t           arb_ctl;
  logic [LANES-1:0]            arb_elig;
  logic [LANES-1:0][PW-1:0]    arb_thr;
  logic [LANES-1:0][IDW-1:0]   arb_best;
  logic [VIW-1:0]              cid;
  logic [VIW-1:0]              req_bit;
  logic [VIW-1:0]              cpl_bit;
  logic [IDW-1:0]              claim_id;

  assign off_e = addr_r - pic_pkg::OFS_ENABLE;
  assign off_c = addr_r - pic_pkg::OFS_CONTEXT;

  always_comb begin
    kind = pic_pkg::RK_NONE;
    pidx = '0;
    wd   = '0;
    ci   = '0;
    creg = '0;
    if (addr_r[1:0] != 2'b00) begin
      kind = pic_pkg::RK_NONE;
    end else if (addr_r < pic_pkg::OFS_PENDING) begin
      pidx = addr_r[11:2];
      if (32'(pidx) <= 32'(NUM_SOURCES)) kind = pic_pkg::RK_PRIO;
    end else if (addr_r < pic_pkg::OFS_ENABLE) begin
      wd = addr_r[11:2];
      if (32'(wd) < 32'(NUM_WORDS)) kind = pic_pkg::RK_PEND;
    end else if (addr_r < pic_pkg::OFS_CONTEXT) begin
      ci = off_e[pic_pkg::ENABLE_SHIFT +: 14];
      wd = {5'd0, off_e[6:2]};
      if ((32'(ci) < 32'(NUM_CONTEXTS)) && (32'(wd) < 32'(NUM_WORDS))) begin
        kind = pic_pkg::RK_ENABLE;
      end
    end else begin
      ci   = {5'd0, off_c[pic_pkg::CONTEXT_SHIFT +: 9]};
      creg = off_c[11:0];
      if (32'(ci) < 32'(NUM_CONTEXTS)) begin
        if (creg == pic_pkg::REG_THRESHOLD) kind = pic_pkg::RK_THRESH;
        else if (creg == pic_pkg::REG_CLAIM) kind = pic_pkg::RK_CLAIM;
      end
    end
  end

  assign didx  = pidx[IDW-1:0];
  assign dword = wd[WW-1:0];
  assign dctx  = ci[CW-1:0];

  // Ids one to NUM_SOURCES exist; every other pending or enable bit stays 0.
  always_comb begin
    for (int b = 0; b < VW; b++) begin
      legal[b] = (b >= 1) && (b <= NUM_SOURCES);
    end
  end

  assign wmask    = legal[{dword, 5'd0} +: 32];
  assign cid      = VIW'(cmp_id_r);
  assign req_bit  = VIW'(src_r);
  assign cpl_bit  = data_r[VIW-1:0];
  assign claim_id = arb_best[NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      arb_elig[l] = pend_r[cid] & en_r[l][cid];
      arb_thr[l]  = thr_r[l];
    end
    arb_elig[NL] = pend_r[cid] & en_r[dctx][cid];
    arb_thr[NL]  = thr_r[dctx];
  end

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    addr_nxt    = addr_r;
    data_nxt    = data_r;
    src_nxt     = src_r;
    clr_nxt     = clr_r;
    pend_nxt    = pend_r;
    gw_nxt      = gw_r;
    en_nxt      = en_r;
    thr_nxt     = thr_r;
    scan_id_nxt = scan_id_r;
    iss_nxt     = iss_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_id_nxt  = cmp_id_r;
    claim_nxt   = claim_r;
    prd_nxt     = prd_r;
    rdata_nxt   = rdata_r;
    err_nxt     = err_r;
    irq_nxt     = irq_r;
    ov_nxt      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_r;
    ram_wdata   = '0;
    ram_raddr   = scan_id_r;
    arb_ctl     = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_r == IDW'(NUM_SOURCES)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          addr_nxt  = in_address;
          data_nxt  = in_write_data;
          src_nxt   = in_source_id;
          rdata_nxt = '0;
          err_nxt   = 1'b0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        ram_raddr   = didx;
        ram_waddr   = didx;
        ram_wdata   = data_r[PW-1:0];
        scan_id_nxt = IDW'(1);
        iss_nxt     = 1'b1;
        cmp_vld_nxt = 1'b0;
        state_nxt   = S_SCAN;
        if (act_r == pic_pkg::ACT_REQUEST) begin
          // The gateway forwards nothing more until the source is completed.
          if ((src_r != 5'd0) && (32'(src_r) <= 32'(NUM_SOURCES)) && !gw_r[req_bit]) begin
            pend_nxt[req_bit] = 1'b1;
            gw_nxt[req_bit]   = 1'b1;
          end
        end else if ((act_r == pic_pkg::ACT_READ) || (act_r == pic_pkg::ACT_WRITE)) begin
          case (kind)
            pic_pkg::RK_PRIO: begin
              if (act_r == pic_pkg::ACT_WRITE) begin
                ram_we = (didx != '0);
              end else begin
                prd_nxt = 1'b1;
              end
            end
            pic_pkg::RK_PEND: begin
              if (act_r == pic_pkg::ACT_READ) rdata_nxt = pend_r[{dword, 5'd0} +: 32];
            end
            pic_pkg::RK_ENABLE: begin
              if (act_r == pic_pkg::ACT_WRITE) begin
                en_nxt[dctx][{dword, 5'd0} +: 32] = data_r & wmask;
              end else begin
                rdata_nxt = en_r[dctx][{dword, 5'd0} +: 32];
              end
            end
            pic_pkg::RK_THRESH: begin
              if (act_r == pic_pkg::ACT_WRITE) begin
                thr_nxt[dctx] = data_r[PW-1:0];
              end else begin
                rdata_nxt = 32'(thr_r[dctx]);
              end
            end
            pic_pkg::RK_CLAIM: begin
              if (act_r == pic_pkg::ACT_WRITE) begin
                if ((data_r != 32'd0) && (data_r <= 32'(NUM_SOURCES)) &&
                    en_r[dctx][cpl_bit]) begin
                  gw_nxt[cpl_bit] = 1'b0;
                end
              end else begin
                claim_nxt = 1'b1;
              end
            end
            default: begin
              err_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // The first scan cycle sees the priority read issued by the access.
        if (prd_r) begin
          rdata_nxt = 32'(ram_rdata);
          prd_nxt   = 1'b0;
        end
        arb_ctl.init = iss_r && (scan_id_r == IDW'(1));
        arb_ctl.step = cmp_vld_r;
        cmp_vld_nxt  = iss_r;
        cmp_id_nxt   = scan_id_r;
        if (iss_r) begin
          if (scan_id_r == IDW'(NUM_SOURCES)) begin
            iss_nxt = 1'b0;
          end else begin
            scan_id_nxt = scan_id_r + 1'b1;
          end
        end else begin
          state_nxt = S_END;
        end
      end

      S_END: begin
        if (claim_r) begin
          // The claim is settled; scan again on the updated pending bits.
          pend_nxt[VIW'(claim_id)] = 1'b0;
          rdata_nxt   = 32'(claim_id);
          claim_nxt   = 1'b0;
          scan_id_nxt = IDW'(1);
          iss_nxt     = 1'b1;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end else begin
          irq_nxt = '0;
          for (int l = 0; l < NL; l++) begin
            irq_nxt[l] = (arb_best[l] != '0);
          end
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      pend_r    <= '0;
      gw_r      <= '0;
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        en_r[c]  <= '0;
        thr_r[c] <= '0;
      end
      iss_r     <= 1'b0;
      cmp_vld_r <= 1'b0;
      claim_r   <= 1'b0;
      prd_r     <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      pend_r    <= pend_nxt;
      gw_r      <= gw_nxt;
      en_r      <= en_nxt;
      thr_r     <= thr_nxt;
      iss_r     <= iss_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      claim_r   <= claim_nxt;
      prd_r     <= prd_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    addr_r    <= addr_nxt;
    data_r    <= data_nxt;
    src_r     <= src_nxt;
    scan_id_r <= scan_id_nxt;
    cmp_id_r  <= cmp_id_nxt;
    rdata_r   <= rdata_nxt;
    err_r     <= err_nxt;
    irq_r     <= irq_nxt;
  end

  pic_prio_ram #(
    .DEPTH (NUM_SOURCES + 1),
    .AW    (IDW),
    .DW    (PW)
  ) u_prio_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pic_arb #(
    .LANES (LANES),
    .IDW   (IDW),
    .PW    (PW)
  ) u_arb (
    .clk       (clk),
    .ctl       (arb_ctl),
    .cand_id   (cmp_id_r),
    .cand_prio (ram_rdata),
    .elig      (arb_elig),
    .thr       (arb_thr),
    .best_id   (arb_best)
  );

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_read_data   = rdata_r;
  assign out_bus_error   = err_r;
  assign out_context_irq = irq_r;

endmodule

### hdl/pic_checker.sv
// Port-level checks on the interrupt controller's command handshake and
// result strobe, with the bind that attaches them. No package dependencies.
module pic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_read_data,
  input logic        out_bus_error
);

  logic accept;
  assign accept = start && !busy;

  // A result is only shown once the block is free for the next transfer.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted transfer keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy && !out_valid))
    else $error("block not busy after an accepted transfer");

  // Strobes never come two in a row, as each item gives exactly one.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A failed access returns no data.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bus_error) |-> (out_read_data == 32'd0))
    else $error("bus error with non-zero read data");

endmodule

bind platform_interrupt_controller pic_checker u_pic_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_read_data   (out_read_data),
  .out_bus_error   (out_bus_error)
);
